>>> src/ising_pkg.sv
// ----------------------------------------------------------------------------
// ising_pkg: shared types and constants for the Ising site update core
// Field widths, register indexes, function codes and reset values.
// ----------------------------------------------------------------------------
package ising_pkg;

  localparam int unsigned MaxSideDef = 256;

  localparam int unsigned RowW    = 8;
  localparam int unsigned DrawW   = 16;
  localparam int unsigned SideCfgW = 9;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned EnergyW = 5;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  localparam logic [SideCfgW-1:0] SideRst      = 9'd20;
  localparam logic [LimitW-1:0]   LimitFourRst = 16'd8869;
  localparam logic [LimitW-1:0]   LimitEightRst = 16'd1200;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LATTICE_SIDE  = 2'd0,
    REG_LIMIT_FOUR    = 2'd1,
    REG_LIMIT_EIGHT   = 2'd2
  } reg_idx_e;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_FLIP = 1'b1
  } func_e;

  typedef logic signed [EnergyW-1:0] energy_t;

  localparam energy_t EnergyFour  = 5'sd4;
  localparam energy_t EnergyEight = 5'sd8;

endpackage

>>> src/ising_metropolis_site_update_core.sv
// ----------------------------------------------------------------------------
// ising_metropolis_site_update_core: Metropolis spin update on a 2D lattice
//
// Channels: the slave stream takes one request per accepted beat. tuser
// carries the function (load a spin or attempt a flip); tdata carries the
// site row and column, the spin to load and a 16-bit uniform draw. The
// master stream returns one result per request: flipped, spin after the
// request and the energy change of the proposed flip.
// The configuration channel writes the lattice side and the two acceptance
// thresholds and is always ready. The user must write it only while the
// core is idle; the core itself does not enforce this. One request is
// worked at a time. A flip attempt reads five spins through the two read
// ports of the spin memory in the read states RD0, RD1 and RD2, then
// passes through the evaluate/write-back state EVAL and the output state
// OUT; a new request is taken only back in IDLE. A load or an off-lattice
// request skips the reads and goes from IDLE straight to EVAL and OUT.
// Reset clears the control state and loads the default configuration; the
// spin memory holds no reset value, each site must be loaded before use.
// A stalled receiver holds the result in the output register; the core
// then waits in its output state before taking the next request.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update_core
  import ising_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MaxSideDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] site_row, [15:8] site_col, [16] spin_in, [32:17] uniform_draw
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] func
  input  logic                s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] flipped, [1] spin_out, [6:2] energy_change
  output logic [OutDataW-1:0] m_axis_tdata,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned SW     = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned AW     = 2 * SW;
  localparam int unsigned DEPTH  = 1 << AW;
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int unsigned CW     = (SIDE_W > SideCfgW) ? SIDE_W : SideCfgW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_EVAL,
    ST_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [SideCfgW-1:0] side_q;
  logic [LimitW-1:0]   limit_four_q;
  logic [LimitW-1:0]   limit_eight_q;
  logic [CW-1:0]       side_ext;
  logic [CW-1:0]       side_use;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q        <= SideRst;
      limit_four_q  <= LimitFourRst;
      limit_eight_q <= LimitEightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LATTICE_SIDE: side_q        <= cfg_data_i[SideCfgW-1:0];
        REG_LIMIT_FOUR:   limit_four_q  <= cfg_data_i[LimitW-1:0];
        REG_LIMIT_EIGHT:  limit_eight_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    side_ext = CW'(side_q);
    if (side_ext < CW'(2)) begin
      side_use = CW'(2);
    end else if (side_ext > CW'(MAX_SIDE)) begin
      side_use = CW'(MAX_SIDE);
    end else begin
      side_use = side_ext;
    end
  end

  // request fields
  logic [RowW-1:0]  in_row;
  logic [RowW-1:0]  in_col;
  logic             in_fire;
  logic             in_range;

  assign in_row   = s_axis_tdata[7:0];
  assign in_col   = s_axis_tdata[15:8];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_range = (CW'(in_row) < side_use) && (CW'(in_col) < side_use);
  assign s_axis_tready = (state_q == ST_IDLE);

  logic             func_q;
  logic [SW-1:0]    row_q;
  logic [SW-1:0]    col_q;
  logic             spin_in_q;
  logic [DrawW-1:0] draw_q;
  logic             in_range_q;

  // wrapped neighbor indexes
  logic [SW-1:0] side_m1;
  logic [SW-1:0] up_idx;
  logic [SW-1:0] down_idx;
  logic [SW-1:0] left_idx;
  logic [SW-1:0] right_idx;

  always_comb begin
    side_m1   = SW'(side_use - CW'(1));
    up_idx    = (row_q == '0) ? side_m1 : row_q - SW'(1);
    down_idx  = (row_q == side_m1) ? '0 : row_q + SW'(1);
    left_idx  = (col_q == '0) ? side_m1 : col_q - SW'(1);
    right_idx = (col_q == side_m1) ? '0 : col_q + SW'(1);
  end

  // spin memory: two read ports, one write port
  logic          spin_mem [DEPTH];
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic          rd_a_q;
  logic          rd_b_q;
  logic          wr_en;
  logic          wr_bit;

  always_comb begin
    case (state_q)
      ST_RD0: begin
        rd_addr_a = {row_q, col_q};
        rd_addr_b = {up_idx, col_q};
      end
      ST_RD1: begin
        rd_addr_a = {down_idx, col_q};
        rd_addr_b = {row_q, left_idx};
      end
      default: begin
        rd_addr_a = {row_q, right_idx};
        rd_addr_b = {row_q, right_idx};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      spin_mem[{row_q, col_q}] <= wr_bit;
    end
    rd_a_q <= spin_mem[rd_addr_a];
    rd_b_q <= spin_mem[rd_addr_b];
  end

  // captured spins
  logic center_q;
  logic up_q;
  logic down_q;
  logic left_q;

  // energy and acceptance
  logic [2:0]        up_cnt;
  logic signed [5:0] four_k;
  logic signed [5:0] de_wide;
  energy_t           de;
  logic              accept;

  always_comb begin
    up_cnt  = 3'(up_q) + 3'(down_q) + 3'(left_q) + 3'(rd_a_q);
    four_k  = $signed({1'b0, up_cnt, 2'b00});
    de_wide = center_q ? (four_k - 6'sd8) : (6'sd8 - four_k);
    de      = energy_t'(de_wide);
    if (de <= 0) begin
      accept = 1'b1;
    end else if (de == EnergyFour) begin
      accept = (draw_q <= limit_four_q);
    end else if (de == EnergyEight) begin
      accept = (draw_q <= limit_eight_q);
    end else begin
      accept = 1'b0;
    end
  end

  logic is_load;

  assign is_load = (func_q == FUNC_LOAD);
  assign wr_en   = (state_q == ST_EVAL) && in_range_q && (is_load || accept);
  assign wr_bit  = is_load ? spin_in_q : ~center_q;

  // result register
  logic    res_flip_q;
  logic    res_spin_q;
  energy_t res_de_q;
  logic    m_valid_q;
  logic    m_flip_q;
  logic    m_spin_q;
  energy_t m_de_q;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_de_q, m_spin_q, m_flip_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      m_flip_q   <= 1'b0;
      m_spin_q   <= 1'b0;
      m_de_q     <= '0;
      func_q     <= FUNC_LOAD;
      in_range_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
        m_flip_q  <= res_flip_q;
        m_spin_q  <= res_spin_q;
        m_de_q    <= res_de_q;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            func_q     <= s_axis_tuser;
            in_range_q <= in_range;
            state_q    <= (in_range && (s_axis_tuser == FUNC_FLIP)) ? ST_RD0 : ST_EVAL;
          end
        end
        ST_RD0: state_q <= ST_RD1;
        ST_RD1: state_q <= ST_RD2;
        ST_RD2: state_q <= ST_EVAL;
        ST_EVAL: state_q <= ST_OUT;
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_q     <= SW'(in_row);
      col_q     <= SW'(in_col);
      spin_in_q <= s_axis_tdata[16];
      draw_q    <= s_axis_tdata[32:17];
    end
    if (state_q == ST_RD1) begin
      center_q <= rd_a_q;
      up_q     <= rd_b_q;
    end
    if (state_q == ST_RD2) begin
      down_q <= rd_a_q;
      left_q <= rd_b_q;
    end
    if (state_q == ST_EVAL) begin
      if (!in_range_q) begin
        res_flip_q <= 1'b0;
        res_spin_q <= 1'b0;
        res_de_q   <= '0;
      end else if (is_load) begin
        res_flip_q <= 1'b0;
        res_spin_q <= spin_in_q;
        res_de_q   <= '0;
      end else begin
        res_flip_q <= accept;
        res_spin_q <= center_q ^ accept;
        res_de_q   <= de;
      end
    end
  end

endmodule

>>> src/ising_chk.sv
// ----------------------------------------------------------------------------
// ising_chk: port checker for the Ising site update core
// Watches the stream ports for result encoding and request spacing.
// ----------------------------------------------------------------------------
module ising_chk
  import ising_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  energy_t out_de;

  assign out_de = energy_t'(m_axis_tdata[6:2]);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // energy change is a multiple of four within -8..8
  a_de_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_de == -5'sd8) || (out_de == -5'sd4) || (out_de == 5'sd0) ||
                      (out_de == 5'sd4) || (out_de == 5'sd8))
    else $error("energy change out of range");

  // a downhill move always flips
  a_downhill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_de < 0) |-> m_axis_tdata[0])
    else $error("downhill move not taken");

  // one request in flight
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in progress");

endmodule

bind ising_metropolis_site_update_core ising_chk u_ising_chk (.*);

>>> tb/sv/site_update_sb_pkg.sv
// ----------------------------------------------------------------------------
// site_update_sb_pkg: result scoreboard for the Ising site update core
// Keeps a shadow of the spin lattice and the three configuration registers,
// works out the expected result of every accepted request and compares each
// result beat from the core against the oldest expectation.
// ----------------------------------------------------------------------------
package site_update_sb_pkg;
  import ising_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic    flipped;
    logic    spin;
    energy_t energy;
  } site_result_t;

  class site_scoreboard;
    bit                  spin_mem [MaxSideDef*MaxSideDef];
    logic [SideCfgW-1:0] side_reg;
    logic [LimitW-1:0]   limit_four;
    logic [LimitW-1:0]   limit_eight;
    site_result_t        expected_q [$];
    int                  errors;
    int                  requests;
    int                  flips_taken;
    int                  outside;
    int                  results;

    function new();
      side_reg    = SideRst;
      limit_four  = LimitFourRst;
      limit_eight = LimitEightRst;
      errors      = 0;
      requests    = 0;
      flips_taken = 0;
      outside     = 0;
      results     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_LATTICE_SIDE: side_reg    = data[SideCfgW-1:0];
        REG_LIMIT_FOUR:   limit_four  = data[LimitW-1:0];
        REG_LIMIT_EIGHT:  limit_eight = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned side_now();
      if (side_reg < 2) return 2;
      if (side_reg > MaxSideDef) return MaxSideDef;
      return side_reg;
    endfunction

    function int spin_val(int unsigned r, int unsigned c);
      return spin_mem[r*MaxSideDef + c] ? 1 : -1;
    endfunction

    function void note_request(func_e f, logic [RowW-1:0] row, logic [RowW-1:0] col,
                               logic spin, logic [DrawW-1:0] draw);
      int unsigned  side;
      int unsigned  addr;
      int unsigned  up;
      int unsigned  down;
      int unsigned  left;
      int unsigned  right;
      int           de;
      bit           take;
      site_result_t r;
      side = side_now();
      r    = '0;
      requests++;
      if (row >= side || col >= side) begin
        outside++;
        expected_q.push_back(r);
        return;
      end
      addr = row*MaxSideDef + col;
      if (f == FUNC_LOAD) begin
        spin_mem[addr] = spin;
        r.spin         = spin;
        expected_q.push_back(r);
        return;
      end
      up    = (row == 0) ? side - 1 : row - 1;
      down  = (row + 1 == side) ? 0 : row + 1;
      left  = (col == 0) ? side - 1 : col - 1;
      right = (col + 1 == side) ? 0 : col + 1;
      de = 2 * spin_val(row, col) * (spin_val(up, col) + spin_val(down, col) +
                                     spin_val(row, left) + spin_val(row, right));
      if (de <= 0) take = 1'b1;
      else if (de == 4) take = (draw <= limit_four);
      else take = (draw <= limit_eight);
      if (take) begin
        spin_mem[addr] = !spin_mem[addr];
        flips_taken++;
      end
      r.flipped = take;
      r.spin    = spin_mem[addr];
      r.energy  = energy_t'(de);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      site_result_t exp_r;
      logic         got_flip;
      logic         got_spin;
      energy_t      got_de;
      results++;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: tdata=%h", data);
        errors++;
        return;
      end
      exp_r    = expected_q.pop_front();
      got_flip = data[0];
      got_spin = data[1];
      got_de   = data[6:2];
      if (got_flip !== exp_r.flipped) begin
        $error("flipped: expected %0d, got %0d", exp_r.flipped, got_flip);
        errors++;
      end
      if (got_spin !== exp_r.spin) begin
        $error("spin_out: expected %0d, got %0d", exp_r.spin, got_spin);
        errors++;
      end
      if (got_de !== exp_r.energy) begin
        $error("energy_change: expected %0d, got %0d", exp_r.energy, got_de);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the Ising Metropolis site update core
// Loads spins and attempts flips over several lattice sides and threshold
// settings, including saturated sides and extreme thresholds, with random
// idle cycles on both streams; every result is checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ising_pkg::*;
  import site_update_sb_pkg::*;

  localparam int StallLimit = 2000;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  site_scoreboard sb = new();
  bit             site_loaded [MaxSideDef*MaxSideDef];
  bit             no_gaps     = 1'b0;
  int             cfg_writes  = 0;
  int             quiet_cycles = 0;

  ising_metropolis_site_update_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      sb.check_result(m_axis_tdata);
    end
  end

  task automatic send_request(func_e f, logic [RowW-1:0] row, logic [RowW-1:0] col,
                              logic spin, logic [DrawW-1:0] draw);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= InDataW'({draw, spin, col, row});
    do @(posedge clk_i); while (!s_axis_tready);
    if (f == FUNC_LOAD && row < sb.side_now() && col < sb.side_now())
      site_loaded[row*MaxSideDef + col] = 1'b1;
    sb.note_request(f, row, col, spin, draw);
  endtask

  task automatic ensure_loaded(int unsigned row, int unsigned col);
    if (!site_loaded[row*MaxSideDef + col])
      send_request(FUNC_LOAD, RowW'(row), RowW'(col), 1'($urandom_range(0, 1)),
                   DrawW'($urandom));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_writes++;
  endtask

  task automatic configure(logic [CfgDataW-1:0] side_data, logic [CfgDataW-1:0] four,
                           logic [CfgDataW-1:0] eight, bit touch_unused);
    drain();
    if (touch_unused) cfg_write(RegUnused, CfgDataW'($urandom));
    cfg_write(REG_LATTICE_SIDE, side_data);
    cfg_write(REG_LIMIT_FOUR, four);
    cfg_write(REG_LIMIT_EIGHT, eight);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    send_request(FUNC_LOAD, 8'd19, 8'd0, 1'b0, 16'd0);
    send_request(FUNC_LOAD, 8'd1, 8'd0, 1'b0, 16'd0);
    send_request(FUNC_LOAD, 8'd0, 8'd19, 1'b0, 16'd0);
    send_request(FUNC_LOAD, 8'd0, 8'd1, 1'b0, 16'd0);
    send_request(FUNC_LOAD, 8'd0, 8'd0, 1'b1, 16'hFFFF);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b0, 16'hFFFF);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b1, LimitEightRst + 16'd1);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b0, LimitEightRst);
    send_request(FUNC_LOAD, 8'd19, 8'd0, 1'b1, 16'd0);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b0, 16'hFFFF);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b0, LimitFourRst + 16'd1);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b1, LimitFourRst);
    send_request(FUNC_LOAD, 8'd1, 8'd0, 1'b1, 16'd0);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b0, 16'hFFFF);
    send_request(FUNC_LOAD, 8'd0, 8'd19, 1'b1, 16'd0);
    send_request(FUNC_LOAD, 8'd0, 8'd1, 1'b1, 16'd0);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b0, 16'd0);
    send_request(FUNC_FLIP, 8'd0, 8'd0, 1'b1, 16'd0);
    send_request(FUNC_LOAD, 8'd20, 8'd0, 1'b1, 16'd0);
    send_request(FUNC_FLIP, 8'd0, 8'd255, 1'b1, 16'd0);
    send_request(FUNC_FLIP, 8'd255, 8'd255, 1'b1, 16'hFFFF);
    send_request(FUNC_LOAD, 8'd19, 8'd19, 1'b1, 16'hFFFF);
  endtask

  task automatic run_random(int n, int unsigned win_r, int unsigned win_c);
    int unsigned side;
    int unsigned row;
    int unsigned col;
    int unsigned up;
    int unsigned down;
    int unsigned left;
    int unsigned right;
    int          lim;
    repeat (n) begin
      side = sb.side_now();
      if (side < MaxSideDef && $urandom_range(0, 9) == 0) begin
        row = $urandom_range(0, 255);
        col = $urandom_range(0, 255);
        if (row < side && col < side) begin
          if ($urandom_range(0, 1)) row = $urandom_range(side, 255);
          else col = $urandom_range(side, 255);
        end
        send_request(func_e'($urandom_range(0, 1)), RowW'(row), RowW'(col),
                     1'($urandom_range(0, 1)), DrawW'($urandom));
      end else begin
        if (side <= 32) begin
          row = $urandom_range(0, side - 1);
          col = $urandom_range(0, side - 1);
        end else begin
          row = (win_r + $urandom_range(0, 4)) % side;
          col = (win_c + $urandom_range(0, 4)) % side;
        end
        if ($urandom_range(0, 9) < 3) begin
          send_request(FUNC_LOAD, RowW'(row), RowW'(col), 1'($urandom_range(0, 1)),
                       DrawW'($urandom));
        end else begin
          up    = (row == 0) ? side - 1 : row - 1;
          down  = (row + 1 == side) ? 0 : row + 1;
          left  = (col == 0) ? side - 1 : col - 1;
          right = (col + 1 == side) ? 0 : col + 1;
          ensure_loaded(row, col);
          ensure_loaded(up, col);
          ensure_loaded(down, col);
          ensure_loaded(row, left);
          ensure_loaded(row, right);
          case ($urandom_range(0, 3))
            0: lim = int'(sb.limit_four) + int'($urandom_range(0, 2)) - 1;
            1: lim = int'(sb.limit_eight) + int'($urandom_range(0, 2)) - 1;
            2: lim = $urandom_range(0, 1) ? 65535 : 0;
            default: lim = $urandom_range(0, 65535);
          endcase
          if (lim < 0) lim = 0;
          if (lim > 65535) lim = 65535;
          send_request(FUNC_FLIP, RowW'(row), RowW'(col), 1'($urandom_range(0, 1)),
                       DrawW'(lim));
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    configure(16'd2, 16'd0, 16'hFFFF, 1'b0);
    run_random(30, 0, 0);

    no_gaps = 1'b1;
    configure(16'd0, 16'hFFFF, 16'd0, 1'b0);
    run_random(30, 0, 0);

    no_gaps = 1'b0;
    configure(16'd1, CfgDataW'($urandom), CfgDataW'($urandom), 1'b0);
    run_random(30, 0, 0);

    configure(16'd256, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random(30, 254, 254);

    no_gaps = 1'b1;
    configure(16'hFFFF, 16'd0, 16'd0, 1'b1);
    run_random(30, 126, 127);

    no_gaps = 1'b0;
    configure(16'd5, CfgDataW'($urandom), CfgDataW'($urandom), 1'b0);
    run_random(30, 0, 0);

    configure(16'd13, CfgDataW'($urandom_range(0, 16383)),
              CfgDataW'($urandom_range(0, 4095)), 1'b0);
    run_random(30, 0, 0);

    configure(CfgDataW'(SideRst), LimitFourRst, LimitEightRst, 1'b1);
    run_random(30, 0, 0);

    drain();
    repeat (12) @(posedge clk_i);

    $display("Covered %0d requests (%0d off the lattice), %0d accepted flips, %0d results",
             sb.requests, sb.outside, sb.flips_taken, sb.results);
    $display("across %0d register writes, sides 2 to 256 with saturation, extreme thresholds",
             cfg_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
